@@ rtl/core/bag_pkg.sv @@
// Shared types and constants of the barometric altitude smoother with gain total.
// Used by the channel interfaces, the controller, the datapath and the divider.
`default_nettype none
package bag_pkg;

	localparam int WINDOW_LEN   = 10;
	localparam int PTR_W        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FILL_W       = $clog2(WINDOW_LEN + 1);
	localparam int P_W          = 17;
	localparam int THR_W        = 14;
	localparam int ALT_W        = 24;
	localparam int GAIN_W       = 32;
	localparam int SUM_W        = ALT_W + $clog2(WINDOW_LEN) + 1;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 17;

	localparam int LOG_FRAC     = 24;
	localparam int E_W          = 5;
	localparam int M_W          = 31;
	localparam int LOG_W        = E_W + LOG_FRAC;
	localparam int ZM_W         = 33;
	localparam int TM_W         = 34;
	localparam int SER_W        = 38;
	localparam int NM_W         = 30;
	localparam int SERIES_TERMS = 24;
	localparam int K_W          = $clog2(SERIES_TERMS + 1);
	localparam int DVS_W        = (FILL_W > K_W) ? FILL_W : K_W;
	localparam int DVD_W        = 40;
	localparam int DIV_BITS     = 8;
	localparam int DIV_CYC      = DVD_W / DIV_BITS;
	localparam int CNT_W        = 5;

	localparam logic [27:0]      EXP_COEF  = 28'd141625448;
	localparam logic [22:0]      ALT_SCALE = 23'd4433000;
	localparam logic [SER_W-1:0] ONE_Q30   = SER_W'(64'd1073741824);
	localparam logic [P_W-1:0]   PREF_RST  = 17'd101325;
	localparam logic [THR_W-1:0] THR_RST   = 14'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF_PRESSURE = 1'b0,
		CFG_CLIMB_THR    = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_P   = 1'b0,
		OP_REF = 1'b1
	} op_sel_t;

	typedef enum logic {
		DIV_TERM = 1'b0,
		DIV_MEAN = 1'b1
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOG_NORM, S_LOG_SQ, S_LOG_SAVE, S_LDIFF, S_ZMUL, S_TMUL, S_TDIV,
		S_TACC, S_ALT_MUL, S_ALT_FIN, S_WIN, S_MLOAD, S_MDIV, S_GAIN, S_DONE
	} state_t;

	typedef struct packed {
		logic           load_in;
		logic           log_norm;
		logic           log_sq;
		logic           log_save;
		op_sel_t        op_sel;
		logic           ldiff;
		logic           zmul;
		logic           div_load;
		div_sel_t       div_sel;
		logic           div_step;
		logic           tacc;
		logic           alt_mul;
		logic           alt_fin;
		logic           win_upd;
		logic           gain_upd;
		logic           out_load;
		logic [K_W-1:0] k;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/bag_in_if.sv @@
// Input channel: one pressure sample per transaction.
// Depends on bag_pkg for the field width.
`default_nettype none
interface bag_in_if;
	logic                      valid;
	logic                      ready;
	logic [bag_pkg::P_W-1:0]   pressure;

	modport source (output valid, output pressure, input ready);
	modport sink   (input valid, input pressure, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bag_out_if.sv @@
// Output channel: smoothed altitude and gain total per transaction.
// Depends on bag_pkg for the field widths.
`default_nettype none
interface bag_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [bag_pkg::ALT_W-1:0] smoothed_altitude;
	logic [bag_pkg::GAIN_W-1:0]       total_gain;

	modport source (output valid, output smoothed_altitude, output total_gain, input ready);
	modport sink   (input valid, input smoothed_altitude, input total_gain, output ready);
endinterface
`default_nettype wire

@@ rtl/core/baro_altitude_smoother_gain_core.sv @@
// Top level of the barometric altitude smoother with elevation gain total.
// Depends on bag_pkg, bag_in_if, bag_out_if, bag_ctrl, bag_datapath and bag_div.
//
// Usage:
//  - sample: one pressure reading (0.01 hPa) per transaction, valid/ready.
//  - result: smoothed altitude (cm, signed) and saturating gain total (cm).
//  - cfg_we/cfg_index/cfg_wdata: index 0 reference pressure, 1 climb threshold;
//    write only while no sample is in flight.
//  - One sample is processed at a time. Between accept and result valid come two
//    24-step log2 squaring passes on one 31x31 multiplier, a 24-term exp series
//    (each term one multiply plus a 5-step divide by the term index), altitude
//    scaling, window update and a 5-step mean divide. A new sample is accepted
//    only once the last one has reached its final step and handed its result on.
//  - The result sits in an output register; a stalled receiver holds it there
//    while the next sample is already being worked on. A finished sample waits
//    in its last step until the output register is free.
//  - Reset clears the window, gain total and smoothed history and restores the
//    register defaults (101325, 100). Window entries are read only once written.
`default_nettype none
module baro_altitude_smoother_gain_core (
	input  logic                              clk,
	input  logic                              arst_n,
	bag_in_if.sink                            sample,
	bag_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [bag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bag_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bag_pkg::*;

	cmd_t cmd;

	bag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	bag_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.pressure          (sample.pressure),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.smoothed_altitude (result.smoothed_altitude),
		.total_gain        (result.total_gain)
	);

	// one sample at a time: after an accepted transaction ready drops
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second sample accepted while one is in flight");

	// a new result never overwrites one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result.valid || result.ready))
		else $error("pending result overwritten");

	// gain total is monotonic across results
	a_gain_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result.total_gain >= $past(result.total_gain))
		else $error("gain total decreased");

	// divider is never loaded and stepped in the same cycle
	a_div_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.div_load, cmd.div_step}))
		else $error("divider load and step collide");
endmodule
`default_nettype wire

@@ rtl/core/bag_div.sv @@
// Unsigned radix-256 restoring divider, eight quotient bits per step.
// Depends on bag_pkg for widths; the divisor is narrow, so each step is short.
`default_nettype none
module bag_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      step,
	input  logic [bag_pkg::DVD_W-1:0] dvd,
	input  logic [bag_pkg::DVS_W-1:0] dvs,
	output logic [bag_pkg::DVD_W-1:0] quo
);
	import bag_pkg::*;

	logic [DVD_W-1:0] q_q;
	logic [DVS_W:0]   r_q;
	logic [DVS_W:0]   d_q;
	logic [DVD_W-1:0] q_n;
	logic [DVS_W:0]   r_n;

	always_comb begin
		q_n = q_q;
		r_n = r_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r_n = {r_n[DVS_W-1:0], q_n[DVD_W-1]};
			q_n = {q_n[DVD_W-2:0], 1'b0};
			if (r_n >= d_q) begin
				r_n = r_n - d_q;
				q_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
			r_q <= '0;
			d_q <= '0;
		end else if (load) begin
			q_q <= dvd;
			r_q <= '0;
			d_q <= {1'b0, dvs};
		end else if (step) begin
			q_q <= q_n;
			r_q <= r_n;
		end
	end

	assign quo = q_q;
endmodule
`default_nettype wire

@@ rtl/core/bag_ctrl.sv @@
// Sequencer: walks the log, series, altitude, window, mean and gain steps.
// Depends on bag_pkg for state_t and cmd_t.
`default_nettype none
module bag_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output bag_pkg::cmd_t cmd
);
	import bag_pkg::*;

	state_t         state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [K_W-1:0]   k_q;
	op_sel_t          op_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_LOG_NORM;
			S_LOG_NORM: state_d = S_LOG_SQ;
			S_LOG_SQ:   if (cnt_q == CNT_W'(LOG_FRAC - 1)) state_d = S_LOG_SAVE;
			S_LOG_SAVE: state_d = (op_q == OP_P) ? S_LOG_NORM : S_LDIFF;
			S_LDIFF:    state_d = S_ZMUL;
			S_ZMUL:     state_d = S_TMUL;
			S_TMUL:     state_d = S_TDIV;
			S_TDIV:     if (cnt_q == CNT_W'(DIV_CYC - 1)) state_d = S_TACC;
			S_TACC:     state_d = (k_q == K_W'(SERIES_TERMS)) ? S_ALT_MUL : S_TMUL;
			S_ALT_MUL:  state_d = S_ALT_FIN;
			S_ALT_FIN:  state_d = S_WIN;
			S_WIN:      state_d = S_MLOAD;
			S_MLOAD:    state_d = S_MDIV;
			S_MDIV:     if (cnt_q == CNT_W'(DIV_CYC - 1)) state_d = S_GAIN;
			S_GAIN:     state_d = S_DONE;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.op_sel = op_q;
		cmd.k      = k_q;
		unique case (state_q)
			S_IDLE:     cmd.load_in = in_valid;
			S_LOG_NORM: cmd.log_norm = 1'b1;
			S_LOG_SQ:   cmd.log_sq = 1'b1;
			S_LOG_SAVE: cmd.log_save = 1'b1;
			S_LDIFF:    cmd.ldiff = 1'b1;
			S_ZMUL:     cmd.zmul = 1'b1;
			S_TMUL: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = DIV_TERM;
			end
			S_TDIV:     cmd.div_step = 1'b1;
			S_TACC:     cmd.tacc = 1'b1;
			S_ALT_MUL:  cmd.alt_mul = 1'b1;
			S_ALT_FIN:  cmd.alt_fin = 1'b1;
			S_WIN:      cmd.win_upd = 1'b1;
			S_MLOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = DIV_MEAN;
			end
			S_MDIV:     cmd.div_step = 1'b1;
			S_GAIN:     cmd.gain_upd = 1'b1;
			S_DONE:     cmd.out_load = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			op_q        <= OP_P;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (state_q == S_IDLE) op_q <= OP_P;
			else if (state_q == S_LOG_SAVE) op_q <= OP_REF;
			if (state_q == S_ZMUL) k_q <= K_W'(1);
			else if (state_q == S_TACC) k_q <= k_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/bag_datapath.sv @@
// Datapath: config registers, log2 squaring unit, exp series, window and gain.
// Depends on bag_pkg and bag_div; driven by cmd_t from bag_ctrl.
`default_nettype none
module bag_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bag_pkg::cmd_t                    cmd,
	input  logic [bag_pkg::P_W-1:0]          pressure,
	input  logic                             cfg_we,
	input  logic [bag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic signed [bag_pkg::ALT_W-1:0] smoothed_altitude,
	output logic [bag_pkg::GAIN_W-1:0]       total_gain
);
	import bag_pkg::*;

	logic [P_W-1:0]          pref_q, p_q;
	logic [THR_W-1:0]        thr_q;
	logic                    zero_q;
	logic [E_W-1:0]          e_q;
	logic [M_W-1:0]          m_q;
	logic [LOG_FRAC-1:0]     frac_q;
	logic [LOG_W-1:0]        la_q, lm_q;
	logic                    zneg_q;
	logic [ZM_W-1:0]         zm_q;
	logic [TM_W-1:0]         tm_q;
	logic signed [SER_W-1:0] sum_q;
	logic [NM_W-1:0]         nm_q;
	logic                    dneg_q;
	logic signed [ALT_W-1:0] alt_q;
	logic signed [ALT_W-1:0] win_q [WINDOW_LEN];
	logic [PTR_W-1:0]        ptr_q;
	logic [FILL_W-1:0]       fill_q;
	logic signed [SUM_W-1:0] wsum_q;
	logic                    mneg_q;
	logic signed [ALT_W-1:0] prev_q, out_alt_q;
	logic [GAIN_W-1:0]       gain_q, out_gain_q;

	// log2 front end
	logic [P_W-1:0]   v;
	logic [E_W-1:0]   e_n;
	logic [M_W-1:0]   m_n;
	logic [2*M_W-1:0] sq_p;
	logic [M_W:0]     sq;

	assign v = (cmd.op_sel == OP_P) ? p_q : pref_q;

	always_comb begin
		e_n = '0;
		for (int i = 1; i < P_W; i++)
			if (v[i]) e_n = E_W'(i);
	end

	assign m_n  = M_W'(v) << (E_W'(M_W - 1) - e_n);
	assign sq_p = m_q * m_q;
	assign sq   = sq_p[2*M_W-1:M_W-1];

	// log difference and series argument
	logic signed [LOG_W:0] ldiff;
	logic [LOG_W+27:0]     zprod;
	assign ldiff = $signed({1'b0, la_q}) - $signed({1'b0, e_q, frac_q});
	assign zprod = lm_q * EXP_COEF + (LOG_W+28)'(1 << 23);

	// divider
	logic [TM_W+ZM_W-1:0] tprod;
	logic [DVD_W-1:0]     dvd, quo;
	logic [DVS_W-1:0]     dvs;
	logic                 wneg;
	logic [SUM_W-1:0]     wmag;

	assign tprod = tm_q * zm_q;
	assign wneg  = wsum_q[SUM_W-1];
	assign wmag  = wneg ? SUM_W'(-wsum_q) : SUM_W'(wsum_q);

	always_comb begin
		if (cmd.div_sel == DIV_TERM) begin
			dvd = DVD_W'(tprod[TM_W+ZM_W-1:30]);
			dvs = DVS_W'(cmd.k);
		end else begin
			dvd = DVD_W'(wmag) + DVD_W'(fill_q >> 1);
			dvs = DVS_W'(fill_q);
		end
	end

	bag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.div_load),
		.step   (cmd.div_step),
		.dvd    (dvd),
		.dvs    (dvs),
		.quo    (quo)
	);

	// altitude scaling
	logic signed [SER_W-1:0] diff;
	logic [SER_W-2:0]        dmag;
	logic [SER_W+21:0]       nprod;
	assign diff  = $signed(ONE_Q30) - sum_q;
	assign dmag  = diff[SER_W-1] ? (SER_W-1)'(-diff) : diff[SER_W-2:0];
	assign nprod = dmag * ALT_SCALE + (SER_W+22)'(1 << 29);

	// window and gain
	logic signed [SUM_W-1:0] alt_ext, old_ext;
	logic [ALT_W-1:0]        qa;
	logic signed [ALT_W-1:0] sm;
	logic signed [ALT_W:0]   delta;
	logic [GAIN_W:0]         gsum;
	logic                    climb;

	assign alt_ext = {{(SUM_W-ALT_W){alt_q[ALT_W-1]}}, alt_q};
	assign old_ext = {{(SUM_W-ALT_W){win_q[ptr_q][ALT_W-1]}}, win_q[ptr_q]};
	assign qa      = quo[ALT_W-1:0];
	assign sm      = mneg_q ? $signed(ALT_W'(0) - qa) : $signed(qa);
	assign delta   = $signed({sm[ALT_W-1], sm}) - $signed({prev_q[ALT_W-1], prev_q});
	assign climb   = !prev_q[ALT_W-1] && (prev_q != '0) &&
	                 (delta > $signed({{(ALT_W+1-THR_W){1'b0}}, thr_q}));
	assign gsum    = {1'b0, gain_q} + (GAIN_W+1)'(delta[ALT_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.win_upd) win_q[ptr_q] <= alt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q     <= PREF_RST;
			thr_q      <= THR_RST;
			ptr_q      <= '0;
			fill_q     <= '0;
			wsum_q     <= '0;
			prev_q     <= '0;
			gain_q     <= '0;
			out_alt_q  <= '0;
			out_gain_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_REF_PRESSURE: pref_q <= cfg_wdata[P_W-1:0];
					CFG_CLIMB_THR:    thr_q  <= cfg_wdata[THR_W-1:0];
					default:          pref_q <= pref_q;
				endcase
			end
			if (cmd.win_upd) begin
				if (fill_q == FILL_W'(WINDOW_LEN)) begin
					wsum_q <= wsum_q - old_ext + alt_ext;
				end else begin
					wsum_q <= wsum_q + alt_ext;
					fill_q <= fill_q + 1'b1;
				end
				ptr_q <= (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
			end
			if (cmd.gain_upd) begin
				prev_q <= sm;
				if (climb) gain_q <= gsum[GAIN_W] ? '1 : gsum[GAIN_W-1:0];
			end
			if (cmd.out_load) begin
				out_alt_q  <= prev_q;
				out_gain_q <= gain_q;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			p_q    <= pressure;
			zero_q <= (pressure == '0) || (pref_q == '0);
		end
		if (cmd.log_norm) begin
			e_q    <= e_n;
			m_q    <= m_n;
			frac_q <= '0;
		end
		if (cmd.log_sq) begin
			m_q    <= sq[M_W] ? sq[M_W:1] : sq[M_W-1:0];
			frac_q <= {frac_q[LOG_FRAC-2:0], sq[M_W]};
		end
		if (cmd.log_save && cmd.op_sel == OP_P) la_q <= {e_q, frac_q};
		if (cmd.ldiff) begin
			zneg_q <= ldiff[LOG_W];
			lm_q   <= ldiff[LOG_W] ? LOG_W'(-ldiff) : ldiff[LOG_W-1:0];
		end
		if (cmd.zmul) begin
			zm_q  <= zprod[LOG_W+27:24];
			tm_q  <= TM_W'(ONE_Q30);
			sum_q <= $signed(ONE_Q30);
		end
		if (cmd.tacc) begin
			tm_q <= quo[TM_W-1:0];
			if (zneg_q && cmd.k[0])
				sum_q <= sum_q - $signed(SER_W'(quo[TM_W-1:0]));
			else
				sum_q <= sum_q + $signed(SER_W'(quo[TM_W-1:0]));
		end
		if (cmd.alt_mul) begin
			dneg_q <= diff[SER_W-1];
			nm_q   <= nprod[SER_W+21:30];
		end
		if (cmd.alt_fin) begin
			if (zero_q)
				alt_q <= '0;
			else if (dneg_q)
				alt_q <= (nm_q > NM_W'(8388608)) ? $signed(24'h800000)
				                                  : $signed(ALT_W'(NM_W'(0) - nm_q));
			else
				alt_q <= (nm_q > NM_W'(8388607)) ? $signed(24'h7FFFFF)
				                                  : $signed(nm_q[ALT_W-1:0]);
		end
		if (cmd.div_load && cmd.div_sel == DIV_MEAN) mneg_q <= wneg;
	end

	assign smoothed_altitude = out_alt_q;
	assign total_gain        = out_gain_q;
endmodule
`default_nettype wire
